// ----- design/ofsa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ofsa_pkg
// Shared sizes, request and status codes, and types of the oldest-free
// surface slot allocator.
// ----------------------------------------------------------------------------
package ofsa_pkg;

    localparam int MAX_SURFACES = 32;
    localparam int AGE_BITS     = 64;
    localparam int SLOT_W       = $clog2(MAX_SURFACES);
    localparam int CNT_W        = $clog2(MAX_SURFACES + 1);
    localparam int CFG_W        = 6;
    localparam int OP_W         = 2;
    localparam int IN_SLOT_W    = 5;
    localparam int STATUS_W     = 3;
    localparam int OUT_SLOT_W   = 5;
    localparam int CMP_W        = 8;

    typedef logic [OP_W-1:0]     t_opcode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_opcode OP_ALLOC   = 2'd0;
    localparam t_opcode OP_RELEASE = 2'd1;
    localparam t_opcode OP_CLEAR   = 2'd2;

    localparam t_status ST_GRANTED   = 3'd0;
    localparam t_status ST_NONE_FREE = 3'd1;
    localparam t_status ST_RELEASED  = 3'd2;
    localparam t_status ST_IGNORED   = 3'd3;
    localparam t_status ST_CLEARED   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Outcome of one pass over the age memory.
    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] best;
    } t_scan_res;

endpackage
`default_nettype wire

// ----- design/ofsa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ofsa_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ofsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- design/ofsa_scan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ofsa_scan
// Walks the age memory one slot per cycle and keeps the free slot with the
// smallest age, the lowest index winning a tie.
// ----------------------------------------------------------------------------
module ofsa_scan
    import ofsa_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [CNT_W-1:0]        i_pool_n,
    input  wire logic [MAX_SURFACES-1:0] i_busy,
    input  wire logic [MAX_SURFACES-1:0] i_age_vld,
    output logic      [SLOT_W-1:0]       o_raddr,
    input  wire logic [AGE_BITS-1:0]     i_rdata,
    output t_scan_res                    o_res
);

    logic                r_run, n_run;
    logic                r_pend, n_pend;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [SLOT_W-1:0]   r_pidx, n_pidx;
    logic                r_found, n_found;
    logic [SLOT_W-1:0]   r_best, n_best;
    logic [AGE_BITS-1:0] r_best_age, n_best_age;
    logic [AGE_BITS-1:0] age;
    logic                issue;
    logic                done;

    assign issue   = r_run && (r_idx < i_pool_n);
    assign done    = r_run && !r_pend && !issue;
    assign o_raddr = r_idx[SLOT_W-1:0];
    // A slot never written since reset or clear holds age zero.
    assign age     = i_age_vld[r_pidx] ? i_rdata : '0;

    always_comb begin
        n_run      = r_run;
        n_pend     = 1'b0;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_found    = r_found;
        n_best     = r_best;
        n_best_age = r_best_age;
        if (i_start) begin
            n_run   = 1'b1;
            n_idx   = '0;
            n_found = 1'b0;
        end else begin
            if (issue) begin
                n_pend = 1'b1;
                n_pidx = r_idx[SLOT_W-1:0];
                n_idx  = r_idx + 1'b1;
            end
            if (r_pend && !i_busy[r_pidx] && (!r_found || age < r_best_age)) begin
                n_found    = 1'b1;
                n_best     = r_pidx;
                n_best_age = age;
            end
            if (done) begin
                n_run = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_run   <= n_run;
            r_pend  <= n_pend;
            r_found <= n_found;
        end
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_best     <= n_best;
        r_best_age <= n_best_age;
    end

    assign o_res.done  = done;
    assign o_res.found = r_found;
    assign o_res.best  = r_best;

endmodule
`default_nettype wire

// ----- design/oldest_free_surface_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oldest_free_surface_allocator
// Grants the free surface slot with the oldest age stamp, releases slots and
// clears the pool.
// ----------------------------------------------------------------------------
// One request is worked on at a time. An allocate reaches the result register
// only after a pass that reads the age memory one slot per cycle; release,
// clear and unused requests skip that pass. The result register lets the
// next request be accepted while a result still waits to be taken. Busy marks
// and age-valid marks live in flip-flops, so reset and clear act at once and
// need no clearing pass. active_surfaces must be written only while no request
// is outstanding; the block itself does not enforce this.
module oldest_free_surface_allocator
    import ofsa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration: active_surfaces.
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [5:0] i_cfg_data,
    // Requests.
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,  // [4:0] slot, [7:5] zero
    input  wire logic [1:0] i_s_axis_tuser,  // [1:0] opcode
    // Results.
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,  // [4:0] granted_slot, [7:5] zero
    output logic [2:0]      o_m_axis_tuser   // [2:0] status
);

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_cfg;
    logic [MAX_SURFACES-1:0] r_busy;
    logic [MAX_SURFACES-1:0] r_age_vld;
    logic [AGE_BITS-1:0]   r_age_cnt;
    t_status               r_res_status;
    logic [SLOT_W-1:0]     r_res_slot;
    logic                  r_ovalid;
    t_status               r_ostatus;
    logic [OUT_SLOT_W-1:0] r_oslot;

    logic [CMP_W-1:0]      pool_wide;
    logic [CNT_W-1:0]      pool_n;
    logic                  in_acc;
    t_opcode               op;
    logic [IN_SLOT_W-1:0]  in_slot;
    logic                  rel_ok;
    logic                  out_free;
    logic                  scan_start;
    logic                  load_out;
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [AGE_BITS-1:0]   ram_rdata;
    t_scan_res             scan_res;

    assign op       = i_s_axis_tuser;
    assign in_slot  = i_s_axis_tdata[IN_SLOT_W-1:0];
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        pool_wide = CMP_W'(r_cfg);
        if (pool_wide > CMP_W'(MAX_SURFACES)) begin
            pool_wide = CMP_W'(MAX_SURFACES);
        end
        pool_n = pool_wide[CNT_W-1:0];
    end

    assign rel_ok = CMP_W'(in_slot) < CMP_W'(pool_n);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (op == OP_ALLOC) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_axis_tready = 1'b0;
        scan_start      = 1'b0;
        load_out        = 1'b0;
        ram_we          = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                scan_start      = i_s_axis_tvalid && (op == OP_ALLOC);
            end
            S_SCAN: begin
                ram_we = scan_res.done && scan_res.found;
            end
            S_DONE: begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CFG_W'(32);
            r_busy    <= '0;
            r_age_vld <= '0;
            r_age_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (in_acc && op == OP_RELEASE && rel_ok) begin
                r_busy[SLOT_W'(in_slot)] <= 1'b0;
            end
            if (in_acc && op == OP_CLEAR) begin
                r_busy    <= '0;
                r_age_vld <= '0;
                r_age_cnt <= '0;
            end
            if (ram_we) begin
                r_busy[scan_res.best]    <= 1'b1;
                r_age_vld[scan_res.best] <= 1'b1;
                r_age_cnt                <= r_age_cnt + 1'b1;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result of the request in flight.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res_slot <= '0;
            priority case (1'b1)
                op == OP_ALLOC:             r_res_status <= ST_NONE_FREE;
                op == OP_RELEASE && rel_ok: r_res_status <= ST_RELEASED;
                op == OP_CLEAR:             r_res_status <= ST_CLEARED;
                default:                    r_res_status <= ST_IGNORED;
            endcase
        end else if (r_state == S_SCAN && scan_res.done) begin
            if (scan_res.found) begin
                r_res_status <= ST_GRANTED;
                r_res_slot   <= scan_res.best;
            end
        end
        if (load_out) begin
            r_ostatus <= r_res_status;
            r_oslot   <= OUT_SLOT_W'(r_res_slot);
        end
    end

    ofsa_ram #(
        .WIDTH (AGE_BITS),
        .DEPTH (MAX_SURFACES)
    ) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (scan_res.best),
        .i_wdata (r_age_cnt),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ofsa_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_pool_n  (pool_n),
        .i_busy    (r_busy),
        .i_age_vld (r_age_vld),
        .o_raddr   (ram_raddr),
        .i_rdata   (ram_rdata),
        .o_res     (scan_res)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_ostatus;
    assign o_m_axis_tdata  = {{(8 - OUT_SLOT_W){1'b0}}, r_oslot};

    // An accepted allocate starts the memory pass in the next cycle.
    a_alloc_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && op == OP_ALLOC) |=> (r_state == S_SCAN))
        else $error("allocate did not start a scan");

    // A grant leaves the granted slot busy and inside the pool.
    a_grant_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_res_status == ST_GRANTED)
            |=> (r_busy[r_res_slot] && (CMP_W'(r_oslot) < CMP_W'(pool_n))))
        else $error("granted slot not busy or outside pool");

    // The age memory is written only at the end of a successful pass.
    a_write_on_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_state == S_DONE && r_res_status == ST_GRANTED))
        else $error("age write without a grant");

endmodule
`default_nettype wire
